/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the I2C byte engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define I2CM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that prop never holds at a rising edge outside reset.
`define I2CM_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);

`endif

/* hw/rtl/i2cm_pkg.sv */
// Package of the I2C byte engine: command codes, step limits and sequencer state.
package i2cm_pkg;

    localparam int          PHASE_COUNT_BITS_DEF = 16;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd400;

    // Command codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Last step index of each command
    localparam logic [4:0] LAST_START = 5'd3;
    localparam logic [4:0] LAST_STOP  = 5'd2;
    localparam logic [4:0] LAST_WRITE = 5'd26;
    localparam logic [4:0] LAST_READ  = 5'd20;

    // Write byte: bit steps end here, then release and ACK clock
    localparam logic [4:0] WR_RELEASE = 5'd24;
    localparam logic [4:0] WR_ACK_HI  = 5'd25;
    // Read byte: bit clocks span 1..16, then ACK drive and clock
    localparam logic [4:0] RD_BITS_END = 5'd16;
    localparam logic [4:0] RD_ACK_SDA  = 5'd17;
    localparam logic [4:0] RD_ACK_HI   = 5'd18;
    localparam logic [4:0] RD_ACK_LO   = 5'd19;

    // Sequencer state carried between ticks
    typedef struct packed {
        logic       running;
        logic [1:0] op;
        logic [4:0] step;
        logic [1:0] wph;     // phase of the current bit in a write, 0..2
        logic [7:0] tx;      // bits still to send, next one at bit 7
        logic       tx_ack;
        logic [7:0] shift;
        logic       ack;
        logic       scl;
        logic       sda;
    } t_seq_state;

    function automatic logic [4:0] last_step(input logic [1:0] op);
        logic [4:0] r;
        unique case (op)
            OP_START: r = LAST_START;
            OP_STOP:  r = LAST_STOP;
            OP_WRITE: r = LAST_WRITE;
            default:  r = LAST_READ;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/i2cm_step.sv */
// Step sequencer of the I2C byte engine: start, sample, advance and line changes.
module i2cm_step
    import i2cm_pkg::*;
(
    input  t_seq_state i_state,
    input  logic       i_start,     // idle tick carrying a command
    input  logic       i_advance,   // hold of the current step has run out
    input  logic [1:0] i_command,
    input  logic [7:0] i_cmd_data,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    output t_seq_state o_state,
    output logic       o_done
);

    always_comb begin
        t_seq_state n;
        logic       apply;
        logic [4:0] idx;
        logic       rd_clk;

        n      = i_state;
        o_done = 1'b0;
        apply  = 1'b0;
        rd_clk = 1'b0;

        if (i_state.running) begin
            if (i_advance) begin
                // Sample SDA on the last tick of a sampling step
                if (i_state.op == OP_WRITE && i_state.step == WR_ACK_HI) begin
                    n.ack = !i_sda_in;
                end
                if (i_state.op == OP_READ && i_state.step != 5'd0
                    && i_state.step <= RD_BITS_END && i_state.step[0]) begin
                    n.shift = {i_state.shift[6:0], i_sda_in};
                end
                // Finish or move to the next step
                if (i_state.step >= last_step(i_state.op)) begin
                    n.running = 1'b0;
                    o_done    = 1'b1;
                end else begin
                    n.step = i_state.step + 5'd1;
                    n.wph  = (i_state.wph == 2'd2) ? 2'd0 : i_state.wph + 2'd1;
                    apply  = 1'b1;
                end
            end
        end else if (i_start) begin
            // Latch the command and enter step zero
            n.running = 1'b1;
            n.op      = i_command;
            n.step    = 5'd0;
            n.wph     = 2'd0;
            n.tx      = i_cmd_data;
            n.tx_ack  = i_send_ack;
            if (i_command == OP_READ) begin
                n.shift = 8'd0;
            end
            apply = 1'b1;
        end

        idx    = n.step;
        rd_clk = (idx != 5'd0) && (idx <= RD_BITS_END);

        // Drive the line change of the new step
        if (apply) begin
            unique case (n.op)
                OP_START: begin
                    unique case (idx)
                        5'd0:    n.sda = 1'b1;
                        5'd1:    n.scl = 1'b1;
                        5'd2:    n.sda = 1'b0;
                        default: n.scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    unique case (idx)
                        5'd0:    n.sda = 1'b0;
                        5'd1:    n.scl = 1'b1;
                        default: n.sda = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    if (idx < WR_RELEASE) begin
                        unique case (n.wph)
                            2'd0: begin
                                n.sda = n.tx[7];
                                n.tx  = {n.tx[6:0], 1'b0};
                            end
                            2'd1:    n.scl = 1'b1;
                            default: n.scl = 1'b0;
                        endcase
                    end else if (idx == WR_RELEASE) begin
                        n.sda = 1'b1;
                    end else begin
                        n.scl = (idx == WR_ACK_HI);
                    end
                end
                default: begin
                    if (idx == 5'd0) begin
                        n.sda = 1'b1;
                    end else if (rd_clk) begin
                        n.scl = idx[0];
                    end else if (idx == RD_ACK_SDA) begin
                        n.sda = !n.tx_ack;
                    end else if (idx == RD_ACK_HI) begin
                        n.scl = 1'b1;
                    end else if (idx == RD_ACK_LO) begin
                        n.scl = 1'b0;
                    end else begin
                        n.sda = 1'b1;
                    end
                end
            endcase
        end

        o_state = n;
    end

endmodule

/* hw/rtl/i2c_master_byte_engine.sv */
// The result beat of a tick beat is registered and offered in the cycle after the beat is accepted.
// Throughput: one tick beat per cycle while result beats are taken; the result register frees as it is taken.
// Each command step is held for phase_ticks beats (0 counts as 1, capped by the counter).
// Reset (synchronous, active low): idle, SCL and SDA released, phase_ticks 400.
// The output register empties on reset; no result beat is pending after it.
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int PHASE_COUNT_BITS = PHASE_COUNT_BITS_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: phase_ticks
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // Tick beats in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] cmd_valid, [8:1] cmd_data, [9] send_ack, [10] sda_in, [15:11] zero
    input  logic [15:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    // Result beats out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_received,
    // [12:5] read_data, [15:13] zero
    output logic [15:0] m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int HW = (PHASE_COUNT_BITS > 16) ? PHASE_COUNT_BITS : 16;
    localparam logic [HW:0] CMAX = ({{HW{1'b0}}, 1'b1} << PHASE_COUNT_BITS) - 1'b1;

    logic [15:0]                 r_phase_ticks;
    logic [PHASE_COUNT_BITS-1:0] r_cnt, n_cnt;
    t_seq_state                  r_seq, n_seq;
    logic                        r_ovalid, n_ovalid;
    logic [15:0]                 r_odata, n_odata;

    logic [HW:0]                 w_pext;
    logic [PHASE_COUNT_BITS-1:0] w_hold;
    logic                        w_fire;
    logic                        w_advance;
    logic                        w_done;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    // Hold length: zero counts as one, cap at the counter's range
    always_comb begin
        w_pext = (HW + 1)'(r_phase_ticks);
        if (w_pext == '0) begin
            w_pext = (HW + 1)'(1);
        end
        if (w_pext > CMAX) begin
            w_pext = CMAX;
        end
        w_hold = w_pext[PHASE_COUNT_BITS-1:0];
    end

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_advance     = r_cnt >= w_hold;

    i2cm_step u_step (
        .i_state    (r_seq),
        .i_start    (s_axis_tdata[0]),
        .i_advance  (w_advance),
        .i_command  (s_axis_tuser),
        .i_cmd_data (s_axis_tdata[8:1]),
        .i_send_ack (s_axis_tdata[9]),
        .i_sda_in   (s_axis_tdata[10]),
        .o_state    (n_seq),
        .o_done     (w_done)
    );

    // Phase counter for the next tick
    always_comb begin
        n_cnt = r_cnt;
        if (r_seq.running) begin
            if (w_advance) begin
                n_cnt = w_done ? '0 : PHASE_COUNT_BITS'(1);
            end else begin
                n_cnt = r_cnt + PHASE_COUNT_BITS'(1);
            end
        end else if (n_seq.running) begin
            n_cnt = PHASE_COUNT_BITS'(1);
        end
    end

    // Result beat from the state after the tick
    always_comb begin
        n_odata = {3'b000, n_seq.shift, n_seq.ack, w_done,
                   n_seq.running, n_seq.sda, n_seq.scl};
        n_ovalid = w_fire || (r_ovalid && !m_axis_tready);
    end

    // Advance state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt          <= '0;
            r_seq.running  <= 1'b0;
            r_seq.op       <= OP_START;
            r_seq.step     <= 5'd0;
            r_seq.wph      <= 2'd0;
            r_seq.tx       <= 8'd0;
            r_seq.tx_ack   <= 1'b0;
            r_seq.shift    <= 8'd0;
            r_seq.ack      <= 1'b0;
            r_seq.scl      <= 1'b1;
            r_seq.sda      <= 1'b1;
            r_ovalid       <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (w_fire) begin
                r_cnt <= n_cnt;
                r_seq <= n_seq;
            end
        end
    end

    // Hold the result register until taken
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_odata <= n_odata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `I2CM_ASSERT(a_idle_cnt_zero, i_clk, i_rst_n, !r_seq.running |-> r_cnt == '0, "counter not clear while idle")
    `I2CM_NEVER(a_run_cnt_zero, i_clk, i_rst_n, r_seq.running && r_cnt == '0, "counter zero while running")
    `I2CM_ASSERT(a_step_bound, i_clk, i_rst_n, r_seq.running |-> r_seq.step <= last_step(r_seq.op), "step beyond last")
    `I2CM_ASSERT(a_done_idle, i_clk, i_rst_n, (w_fire && w_done) |=> !r_seq.running && m_axis_tdata[3], "done without going idle")

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the I2C master byte engine: stream stimulus, tick predictor.
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    typedef enum int {
        STALL_NONE,
        STALL_SEND,
        STALL_RECV,
        STALL_BOTH
    } t_stall_mode;

    // One timer tick as it enters the block
    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] op;
        logic [7:0] data;
        logic       send_ack;
        logic       sda_in;
    } t_tick;

    // Bus state after a tick, laid out as on m_axis_tdata
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] rx_byte;
        logic       ack;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } t_bus_result;

    // Directed row: optional phase write, the command tick, optional fixed result
    typedef struct packed {
        logic        set_cfg;
        logic [15:0] cfg;
        logic        cmd_valid;
        logic [1:0]  op;
        logic [7:0]  data;
        logic        send_ack;
        logic        sda;
        logic        typed;
        logic [15:0] exp;
    } t_dir_row;

    localparam int N_DIR = 17;
    localparam int RAND_TICKS = 170;
    // A long hold is watched this many ticks, then shortened to one
    localparam int LONG_HOLD_TICKS = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    t_stall_mode stall_mode = STALL_NONE;
    int          mismatch_count = 0;
    t_bus_result expected_bus_q [$];
    t_dir_row    dir_rows [N_DIR];

    // Engine copy kept in step with every accepted tick
    logic [15:0] engine_phase = PHASE_TICKS_RESET;
    int unsigned engine_count = 0;
    logic [4:0]  engine_step = '0;
    logic [1:0]  engine_op = OP_START;
    logic        engine_running = 1'b0;
    logic [7:0]  engine_rx = '0;
    logic        engine_ack = 1'b0;
    logic        engine_scl = 1'b1;
    logic        engine_sda = 1'b1;
    logic [7:0]  engine_tx = '0;
    logic        engine_tx_ack = 1'b0;

    i2c_master_byte_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int send_idle_pct(input t_stall_mode m);
        case (m)
            STALL_SEND: return 49;
            STALL_BOTH: return 9;
            default:    return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input t_stall_mode m);
        case (m)
            STALL_RECV: return 49;
            STALL_BOTH: return 9;
            default:    return 0;
        endcase
    endfunction

    // Ticks a step is held: zero counts as one, capped by the counter width
    function automatic int unsigned hold_len();
        int unsigned p;
        int unsigned cap;
        p = engine_phase;
        cap = (32'd1 << PHASE_COUNT_BITS_DEF) - 1;
        if (p == 0) p = 1;
        if (p > cap) p = cap;
        return p;
    endfunction

    function automatic logic [4:0] final_step_of(input logic [1:0] op);
        case (op)
            OP_START: return LAST_START;
            OP_STOP:  return LAST_STOP;
            OP_WRITE: return LAST_WRITE;
            default:  return LAST_READ;
        endcase
    endfunction

    // Change the one line that step idx of the running command moves
    function automatic void drive_lines(input logic [4:0] idx);
        int bitpos;
        int ph;
        case (engine_op)
            OP_START: begin
                case (idx)
                    5'd0:    engine_sda = 1'b1;
                    5'd1:    engine_scl = 1'b1;
                    5'd2:    engine_sda = 1'b0;
                    default: engine_scl = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (idx)
                    5'd0:    engine_sda = 1'b0;
                    5'd1:    engine_scl = 1'b1;
                    default: engine_sda = 1'b1;
                endcase
            end
            OP_WRITE: begin
                if (idx < WR_RELEASE) begin
                    bitpos = 7 - idx / 3;
                    ph = idx % 3;
                    if (ph == 0) engine_sda = engine_tx[bitpos];
                    else engine_scl = (ph == 1);
                end else if (idx == WR_RELEASE) begin
                    engine_sda = 1'b1;
                end else begin
                    engine_scl = (idx == WR_ACK_HI);
                end
            end
            default: begin
                if (idx == 5'd0) engine_sda = 1'b1;
                else if (idx <= RD_BITS_END) engine_scl = idx[0];
                else if (idx == RD_ACK_SDA) engine_sda = !engine_tx_ack;
                else if (idx == RD_ACK_HI) engine_scl = 1'b1;
                else if (idx == RD_ACK_LO) engine_scl = 1'b0;
                else engine_sda = 1'b1;
            end
        endcase
    endfunction

    // Sample SDA at the close of a clock-high step
    function automatic void sample_line(input logic [4:0] idx, input logic sda);
        if (engine_op == OP_WRITE) begin
            if (idx == WR_ACK_HI) engine_ack = !sda;
        end else if (engine_op == OP_READ) begin
            if (idx >= 5'd1 && idx <= RD_BITS_END && idx[0])
                engine_rx = {engine_rx[6:0], sda};
        end
    endfunction

    // Advance the engine by one tick and return the bus state after it
    function automatic t_bus_result advance_engine(input t_tick t);
        t_bus_result r;
        logic done;
        done = 1'b0;
        if (engine_running) begin
            if (engine_count >= hold_len()) begin
                sample_line(engine_step, t.sda_in);
                if (engine_step >= final_step_of(engine_op)) begin
                    engine_running = 1'b0;
                    done = 1'b1;
                    engine_count = 0;
                end else begin
                    engine_step = engine_step + 5'd1;
                    drive_lines(engine_step);
                    engine_count = 1;
                end
            end else begin
                engine_count = engine_count + 1;
            end
        end else if (t.cmd_valid) begin
            engine_op = t.op;
            engine_tx = t.data;
            engine_tx_ack = t.send_ack;
            if (t.op == OP_READ) engine_rx = '0;
            engine_running = 1'b1;
            engine_step = '0;
            drive_lines(5'd0);
            engine_count = 1;
        end
        r.pad = '0;
        r.rx_byte = engine_rx;
        r.ack = engine_ack;
        r.done = done;
        r.busy = engine_running;
        r.sda = engine_sda;
        r.scl = engine_scl;
        return r;
    endfunction

    // Offer one tick beat, wait for it to be taken, then record what it should give
    task automatic push_tick(input t_tick t, input logic typed, input t_bus_result fixed);
        t_bus_result r;
        while ($urandom_range(99) < send_idle_pct(stall_mode)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, t.sda_in, t.send_ack, t.data, t.cmd_valid};
        s_axis_tuser <= t.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = advance_engine(t);
        expected_bus_q.push_back(typed ? fixed : r);
    endtask

    // Noise tick while a command runs: any command here must be ignored
    function automatic t_tick busy_tick(input logic sda);
        t_tick t;
        t.cmd_valid = 1'($urandom_range(1));
        t.op = 2'($urandom_range(3));
        t.data = 8'($urandom_range(255));
        t.send_ack = 1'($urandom_range(1));
        t.sda_in = sda;
        return t;
    endfunction

    // Hold the sender until every result beat has been taken
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_phase(input logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        engine_phase = v;
    endtask

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            mismatch_count++;
        end
    endtask

    // Receiver: stall at random as the current mode asks
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct(stall_mode));
    end

    // Compare each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_bus_result e;
        t_bus_result a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a = m_axis_tdata;
            if (expected_bus_q.size() == 0) begin
                $display("%0t: unexpected result beat %0h", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                e = expected_bus_q.pop_front();
                check_field("scl_out", e.scl, a.scl);
                check_field("sda_out", e.sda, a.sda);
                check_field("busy", e.busy, a.busy);
                check_field("done", e.done, a.done);
                check_field("ack_received", e.ack, a.ack);
                check_field("read_data", e.rx_byte, a.rx_byte);
                check_field("pad", e.pad, a.pad);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_tick t;
        t_stall_mode modes [6];
        logic [15:0] phases [6];

        dir_rows = '{
            // idle after reset: lines released
            '{1'b0, 16'd0, 1'b0, OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0003},
            // start at the reset phase length: first step leaves both high, busy
            '{1'b0, 16'd0, 1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0007},
            // zero phase length, treated as one
            '{1'b1, 16'd0, 1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_WRITE, 8'h00, 1'b1, 1'b1, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_READ,  8'hFF, 1'b0, 1'b0, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_READ,  8'h3C, 1'b1, 1'b0, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_STOP,  8'h00, 1'b0, 1'b1, 1'b0, 16'h0},
            '{1'b1, 16'd1, 1'b1, OP_START, 8'hFF, 1'b1, 1'b0, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_READ,  8'h00, 1'b0, 1'b1, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_STOP,  8'h00, 1'b1, 1'b0, 1'b0, 16'h0},
            '{1'b1, 16'd2, 1'b1, OP_WRITE, 8'h80, 1'b1, 1'b0, 1'b0, 16'h0},
            '{1'b0, 16'd0, 1'b1, OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, 16'h0},
            // longest hold the register allows
            '{1'b1, 16'hFFFF, 1'b1, OP_STOP, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0},
            '{1'b1, 16'd3, 1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0}
        };
        modes = '{STALL_NONE, STALL_SEND, STALL_RECV, STALL_BOTH, STALL_SEND, STALL_NONE};
        phases = '{16'd1, 16'd2, 16'd0, 16'd3, 16'($urandom_range(5, 1)),
                   16'($urandom_range(8, 1))};

        // Hold reset, then release at an edge
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: each command runs to completion under noise commands
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg) begin
                drain_all();
                write_phase(dir_rows[i].cfg);
            end
            t.cmd_valid = dir_rows[i].cmd_valid;
            t.op = dir_rows[i].op;
            t.data = dir_rows[i].data;
            t.send_ack = dir_rows[i].send_ack;
            t.sda_in = dir_rows[i].sda;
            push_tick(t, dir_rows[i].typed, dir_rows[i].exp);
            while (engine_running) begin
                // Shorten a long hold once it has been seen to last
                if (engine_phase > 16'(LONG_HOLD_TICKS)
                    && engine_count >= LONG_HOLD_TICKS) begin
                    drain_all();
                    write_phase(16'd1);
                end
                push_tick(busy_tick(dir_rows[i].sda), 1'b0, '0);
            end
        end

        // Random phases: commands offered at random while idle, noise while busy
        foreach (modes[p]) begin
            drain_all();
            write_phase(phases[p]);
            stall_mode = modes[p];
            for (int n = 0; n < RAND_TICKS; n++) begin
                if (p == 1 && n == RAND_TICKS / 2) drain_all();
                t = busy_tick(1'($urandom_range(1)));
                if (!engine_running) t.cmd_valid = ($urandom_range(99) < 80);
                else t.cmd_valid = ($urandom_range(3) == 0);
                if ($urandom_range(9) == 0) t.data = $urandom_range(1) ? 8'hFF : 8'h00;
                push_tick(t, 1'b0, '0);
            end
            while (engine_running) push_tick(busy_tick(1'($urandom_range(1))), 1'b0, '0);
        end

        // Let the last beats out, then report
        drain_all();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bus_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* i2c_master_byte_engine.f */
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_step.sv
hw/rtl/i2c_master_byte_engine.sv
sim/testbench.sv
